/* rtl/clr_pkg.sv */
`default_nettype none

package clr_pkg;

    // coordinate and screen geometry
    localparam int COORD_BITS = 12;
    localparam int DIM_BITS   = 11;
    localparam int ADDR_BITS  = 20;
    localparam int COLOR_BITS = 8;

    // reset values of the screen size registers
    localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RESET  = DIM_BITS'(320);
    localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RESET = DIM_BITS'(200);

    // request function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } cfg_index_t;

    // line engine modes
    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_HORZ = 4'b0010,
        MODE_VERT = 4'b0100,
        MODE_DIAG = 4'b1000
    } line_mode_t;

    typedef struct packed {
        logic                          func;
        logic signed [COORD_BITS-1:0]  x_start;
        logic signed [COORD_BITS-1:0]  y_start;
        logic signed [COORD_BITS-1:0]  x_end;
        logic signed [COORD_BITS-1:0]  y_end;
        logic [COLOR_BITS-1:0]         line_color;
    } clr_req_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  pixel_x;
        logic signed [COORD_BITS-1:0]  pixel_y;
        logic [ADDR_BITS-1:0]          pixel_address;
        logic [COLOR_BITS-1:0]         pixel_color;
        logic                          visible;
        logic                          last;
    } clr_pixel_t;

endpackage

`default_nettype wire

/* rtl/clipped_line_rasterizer_core.sv */
`default_nettype none

// channel   | ports                      | moves
// ----------+----------------------------+------------------------------------
// request   | s_valid s_ready s_payload  | start (endpoints, color) or step
// pixel     | m_valid m_ready m_payload  | one pixel write per busy-line step
// config    | cfg_wr_en cfg_index cfg_data | screen width / height, no wait
//
// one request is taken per clock while s_ready is high; a step request on a busy
// line puts its pixel in the output or skid register; a start request gives none.
// the per-request work is a single 11x11 multiply and add between the line
// state registers and a two-entry output buffer (output register plus skid).
// s_ready drops only when both output entries are full under a stalled m_ready.
// synchronous active-low reset: engine idle, output buffer empty, 320x200 screen.

module clipped_line_rasterizer_core
    import clr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  clr_req_t             s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output clr_pixel_t           m_payload,
    input  logic                 cfg_wr_en,
    input  cfg_index_t           cfg_index,
    input  logic [DIM_BITS-1:0]  cfg_data
);

    localparam int CB = COORD_BITS;

    // configuration registers
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;

    // line state
    line_mode_t              mode_reg, mode_next;
    logic signed [CB-1:0]    cur_col_reg, cur_col_next;
    logic signed [CB-1:0]    cur_row_reg, cur_row_next;
    logic signed [CB-1:0]    end_col_reg, end_col_next;
    logic signed [CB-1:0]    end_row_reg, end_row_next;
    logic [CB-1:0]           span_dx_reg, span_dx_next;
    logic signed [CB:0]      span_dy_reg, span_dy_next;
    logic                    col_neg_reg, col_neg_next;
    logic                    row_neg_reg, row_neg_next;
    logic signed [CB+1:0]    err_reg, err_next;
    logic [COLOR_BITS-1:0]   color_reg, color_next;

    // output buffer
    clr_pixel_t main_reg, skid_reg;
    logic       main_valid_reg, skid_valid_reg;

    // start decode signals
    logic signed [CB:0] x1e, y1e, x2e, y2e, w_e, h_e;
    logic signed [CB:0] h_lo, h_hi, h_lo_c, h_hi_c;
    logic signed [CB:0] v_lo, v_hi, v_lo_c, v_hi_c;
    logic signed [CB:0] dx_d, dy_d, dx_abs, dy_abs;
    logic signed [CB+1:0] err_init;
    logic               h_ok, v_ok;

    // step signals
    logic signed [CB+2:0] e2, dy_w, dx_w;
    logic signed [CB+1:0] err_add_dy, err_add_dx;
    logic                 take_col, take_row, fin;
    logic                 accept, produce;

    // pixel emission signals
    logic                    pix_vis;
    logic [2*DIM_BITS-1:0]   addr_prod, addr_sum;
    clr_pixel_t              pix;

    localparam logic signed [CB:0] ONE_E = (CB+1)'(1);

    assign accept    = s_valid && s_ready;
    assign s_ready   = !skid_valid_reg;
    assign m_valid   = main_valid_reg;
    assign m_payload = main_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SCREEN_WIDTH_RESET;
            height_reg <= SCREEN_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // endpoint decode for a start request
    always_comb begin
        x1e = {s_payload.x_start[CB-1], s_payload.x_start};
        y1e = {s_payload.y_start[CB-1], s_payload.y_start};
        x2e = {s_payload.x_end[CB-1], s_payload.x_end};
        y2e = {s_payload.y_end[CB-1], s_payload.y_end};
        w_e = {{(CB+1-DIM_BITS){1'b0}}, width_reg};
        h_e = {{(CB+1-DIM_BITS){1'b0}}, height_reg};

        // horizontal span, clamped to the row
        h_lo   = (x1e < x2e) ? x1e : x2e;
        h_hi   = (x1e < x2e) ? x2e : x1e;
        h_lo_c = h_lo[CB] ? '0 : h_lo;
        h_hi_c = (h_hi >= w_e) ? (w_e - ONE_E) : h_hi;
        h_ok   = !y1e[CB] && (y1e < h_e) && !(h_hi_c < h_lo_c);

        // vertical span, clamped to the column
        v_lo   = (y1e < y2e) ? y1e : y2e;
        v_hi   = (y1e < y2e) ? y2e : y1e;
        v_lo_c = v_lo[CB] ? '0 : v_lo;
        v_hi_c = (v_hi >= h_e) ? (h_e - ONE_E) : v_hi;
        v_ok   = !x1e[CB] && (x1e < w_e) && !(v_hi_c < v_lo_c);

        // bresenham setup
        dx_d     = x2e - x1e;
        dy_d     = y2e - y1e;
        dx_abs   = dx_d[CB] ? -dx_d : dx_d;
        dy_abs   = dy_d[CB] ? -dy_d : dy_d;
        err_init = {2'b00, dx_abs[CB-1:0]} - {dy_abs[CB], dy_abs};
    end

    // bresenham step decisions
    always_comb begin
        e2         = {err_reg, 1'b0};
        dy_w       = {{2{span_dy_reg[CB]}}, span_dy_reg};
        dx_w       = {3'b000, span_dx_reg};
        take_col   = (e2 >= dy_w);
        take_row   = (e2 <= dx_w);
        err_add_dy = take_col ? {span_dy_reg[CB], span_dy_reg} : '0;
        err_add_dx = take_row ? {2'b00, span_dx_reg} : '0;
        fin        = (cur_col_reg == end_col_reg) && (cur_row_reg == end_row_reg);
    end

    // pixel at the current position
    always_comb begin
        pix_vis = !cur_col_reg[CB-1] && !cur_row_reg[CB-1]
                  && ({1'b0, cur_col_reg[CB-2:0]} < {{(CB-DIM_BITS){1'b0}}, width_reg})
                  && ({1'b0, cur_row_reg[CB-2:0]} < {{(CB-DIM_BITS){1'b0}}, height_reg});
        addr_prod = cur_row_reg[DIM_BITS-1:0] * width_reg;
        addr_sum  = addr_prod + {{DIM_BITS{1'b0}}, cur_col_reg[DIM_BITS-1:0]};
        pix.pixel_x       = cur_col_reg;
        pix.pixel_y       = cur_row_reg;
        pix.pixel_address = pix_vis ? addr_sum[ADDR_BITS-1:0] : '0;
        pix.pixel_color   = color_reg;
        pix.visible       = pix_vis;
        pix.last          = fin;
    end

    // line state update
    always_comb begin
        mode_next    = mode_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        end_col_next = end_col_reg;
        end_row_next = end_row_reg;
        span_dx_next = span_dx_reg;
        span_dy_next = span_dy_reg;
        col_neg_next = col_neg_reg;
        row_neg_next = row_neg_reg;
        err_next     = err_reg;
        color_next   = color_reg;
        produce      = 1'b0;

        if (accept) begin
            if (s_payload.func == FUNC_START) begin
                color_next = s_payload.line_color;
                mode_next  = MODE_IDLE;
                if (y1e == y2e) begin
                    if (h_ok) begin
                        cur_col_next = h_lo_c[CB-1:0];
                        end_col_next = h_hi_c[CB-1:0];
                        cur_row_next = s_payload.y_start;
                        end_row_next = s_payload.y_start;
                        mode_next    = MODE_HORZ;
                    end
                end else if (x1e == x2e) begin
                    if (v_ok) begin
                        cur_row_next = v_lo_c[CB-1:0];
                        end_row_next = v_hi_c[CB-1:0];
                        cur_col_next = s_payload.x_start;
                        end_col_next = s_payload.x_start;
                        mode_next    = MODE_VERT;
                    end
                end else begin
                    span_dx_next = dx_abs[CB-1:0];
                    span_dy_next = -dy_abs;
                    col_neg_next = !(x1e < x2e);
                    row_neg_next = !(y1e < y2e);
                    err_next     = err_init;
                    cur_col_next = s_payload.x_start;
                    cur_row_next = s_payload.y_start;
                    end_col_next = s_payload.x_end;
                    end_row_next = s_payload.y_end;
                    mode_next    = MODE_DIAG;
                end
            end else if (mode_reg != MODE_IDLE) begin
                produce = 1'b1;
                if (fin) begin
                    mode_next = MODE_IDLE;
                end else begin
                    unique case (mode_reg)
                        MODE_HORZ: cur_col_next = cur_col_reg + CB'(1);
                        MODE_VERT: cur_row_next = cur_row_reg + CB'(1);
                        MODE_DIAG: begin
                            err_next = err_reg + err_add_dy + err_add_dx;
                            if (take_col) begin
                                cur_col_next = col_neg_reg ? cur_col_reg - CB'(1)
                                                           : cur_col_reg + CB'(1);
                            end
                            if (take_row) begin
                                cur_row_next = row_neg_reg ? cur_row_reg - CB'(1)
                                                           : cur_row_reg + CB'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    // line state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
        end else begin
            mode_reg <= mode_next;
        end
        cur_col_reg <= cur_col_next;
        cur_row_reg <= cur_row_next;
        end_col_reg <= end_col_next;
        end_row_reg <= end_row_next;
        span_dx_reg <= span_dx_next;
        span_dy_reg <= span_dy_next;
        col_neg_reg <= col_neg_next;
        row_neg_reg <= row_neg_next;
        err_reg     <= err_next;
        color_reg   <= color_next;
    end

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= produce;
            end
        end else if (produce) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
            end else if (produce) begin
                main_reg <= pix;
            end
        end else if (produce) begin
            skid_reg <= pix;
        end
    end

endmodule

`default_nettype wire

/* rtl/clr_checker.sv */
`default_nettype none

module clr_checker
    import clr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input clr_req_t             s_payload,
    input logic                 m_valid,
    input logic                 m_ready,
    input clr_pixel_t           m_payload
);

    // reset empties the output buffer
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("pixel shown right after reset");

    // a start request into an empty output never produces a pixel
    a_start_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_payload.func == FUNC_START) && !m_valid) |=> !m_valid)
        else $error("start request produced a pixel");

    // a stalled pixel stays offered
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("pixel withdrawn while stalled");

    // a stalled pixel keeps its payload
    a_payload_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_payload))
        else $error("pixel changed while stalled");

endmodule

bind clipped_line_rasterizer_core clr_checker u_clr_checker (.*);

`default_nettype wire
